@@ hdl/ibss_pkg.sv @@
// ibss_pkg: shared types and codes for the indexed byte sequence store.
// Used by ibss_check and indexed_byte_sequence_store_top; no dependencies.
package ibss_pkg;

  // Field widths fixed by the interface
  localparam int unsigned KIND_W = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned STAT_W = 2;

  // Operation codes carried on in_kind
  localparam logic [KIND_W-1:0] KIND_APPEND       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE_FIRST = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE_LAST  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DUMP         = 3'd5;

  // Status codes carried on out_status
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Work the sequencer has to do for an accepted command
  typedef enum logic [2:0] {
    OP_NONE,      // status-only result, store unchanged
    OP_APPEND,    // single write at the tail
    OP_INSERT,    // shift up from the tail, then write
    OP_REMOVE,    // shift down from the index
    OP_DROP_LAST, // count decrement only
    OP_DUMP       // read out every element
  } op_t;

  // Decoded command from the checker to the sequencer
  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  start_idx;
  } chk_t;

endpackage

@@ hdl/indexed_byte_sequence_store_top.sv @@
// Indexed byte sequence store: ordered list of up to CAPACITY bytes held in a
// one-write, one-read memory with a fill count, walked by a small sequencer.
// A command is taken when start is high and busy is low; every result beat
// appears for exactly one cycle with out_strobe high and cannot be stalled.
// Append, remove-last and every rejected command give their beat the cycle
// after acceptance and leave busy low, so one such command per cycle is taken.
// Insert at index p moves the elements from the tail down to p up one slot, and a
// remove at index p moves the elements above p down one slot (remove first is p = 0):
// each moved element costs one read and one write on the memory port.
// Dump reads each element and gives its beat before reading the next one.
// Depends on ibss_pkg and ibss_check.
module indexed_byte_sequence_store_top #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ibss_pkg::KIND_W-1:0]  in_kind,
  input  logic [ibss_pkg::POS_W-1:0]   in_position,
  input  logic [ibss_pkg::BYTE_W-1:0]  in_byte_in,
  output logic                         out_strobe,
  output logic [ibss_pkg::STAT_W-1:0]  out_status,
  output logic [ibss_pkg::CNT_W-1:0]   out_fill_count,
  output logic [ibss_pkg::BYTE_W-1:0]  out_byte_out,
  output logic                         out_byte_valid,
  output logic                         out_last
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_DMP_RD,
    S_DMP_OUT
  } state_t;

  state_t                      state_r;
  logic [ibss_pkg::CNT_W-1:0]  count_r;
  logic [ibss_pkg::CNT_W-1:0]  idx_r;
  logic [ibss_pkg::POS_W-1:0]  pos_r;
  logic [ibss_pkg::BYTE_W-1:0] byte_r;
  logic [ibss_pkg::BYTE_W-1:0] rdata_r;

  logic                        strobe_r;
  logic [ibss_pkg::STAT_W-1:0] status_r;
  logic [ibss_pkg::CNT_W-1:0]  fill_r;
  logic [ibss_pkg::BYTE_W-1:0] bout_r;
  logic                        bvalid_r;
  logic                        last_r;

  logic [ibss_pkg::BYTE_W-1:0] mem [CAPACITY];

  ibss_pkg::chk_t              chk;
  logic                        accept;
  logic [ibss_pkg::CNT_W-1:0]  idx_inc;
  logic [ibss_pkg::CNT_W-1:0]  idx_dec;
  logic                        ins_put;
  logic                        rem_end;

  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [ibss_pkg::BYTE_W-1:0] mem_wd;
  logic                        mem_re;
  logic [AW-1:0]               mem_ra;

  // Command checks
  ibss_check #(
    .CAPACITY (CAPACITY)
  ) u_check (
    .kind     (in_kind),
    .position (in_position),
    .count    (count_r),
    .chk      (chk)
  );

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;

  // Shared index step and compares
  assign idx_inc = idx_r + ibss_pkg::CNT_W'(1);
  assign idx_dec = idx_r - ibss_pkg::CNT_W'(1);
  assign ins_put = (idx_r == ibss_pkg::CNT_W'(pos_r));
  assign rem_end = (idx_inc >= count_r);

  // Memory port steering
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r[AW-1:0];
    mem_wd = rdata_r;
    mem_re = 1'b0;
    mem_ra = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept && chk.op == ibss_pkg::OP_APPEND) begin
          mem_we = 1'b1;
          mem_wa = count_r[AW-1:0];
          mem_wd = in_byte_in;
        end
      end
      S_INS_RD: begin
        if (ins_put) begin
          mem_we = 1'b1;
          mem_wd = byte_r;
        end else begin
          mem_re = 1'b1;
          mem_ra = idx_dec[AW-1:0];
        end
      end
      S_INS_WR: begin
        mem_we = 1'b1;
      end
      S_REM_RD: begin
        if (!rem_end) begin
          mem_re = 1'b1;
          mem_ra = idx_inc[AW-1:0];
        end
      end
      S_REM_WR: begin
        mem_we = 1'b1;
      end
      S_DMP_RD: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Element memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r  <= chk.start_idx;
            pos_r  <= in_position;
            byte_r <= in_byte_in;
            case (chk.op)
              ibss_pkg::OP_NONE: begin
                strobe_r <= 1'b1;
                status_r <= chk.status;
                fill_r   <= count_r;
                bout_r   <= '0;
                bvalid_r <= 1'b0;
                last_r   <= 1'b1;
              end
              ibss_pkg::OP_APPEND: begin
                count_r  <= count_r + ibss_pkg::CNT_W'(1);
                strobe_r <= 1'b1;
                status_r <= ibss_pkg::ST_DONE;
                fill_r   <= count_r + ibss_pkg::CNT_W'(1);
                bout_r   <= '0;
                bvalid_r <= 1'b0;
                last_r   <= 1'b1;
              end
              ibss_pkg::OP_DROP_LAST: begin
                count_r  <= count_r - ibss_pkg::CNT_W'(1);
                strobe_r <= 1'b1;
                status_r <= ibss_pkg::ST_DONE;
                fill_r   <= count_r - ibss_pkg::CNT_W'(1);
                bout_r   <= '0;
                bvalid_r <= 1'b0;
                last_r   <= 1'b1;
              end
              ibss_pkg::OP_INSERT: state_r <= S_INS_RD;
              ibss_pkg::OP_REMOVE: state_r <= S_REM_RD;
              ibss_pkg::OP_DUMP:   state_r <= S_DMP_RD;
              default: begin
              end
            endcase
          end
        end
        // insert: move elements up one slot from the tail down to the index
        S_INS_RD: begin
          if (ins_put) begin
            count_r  <= count_r + ibss_pkg::CNT_W'(1);
            strobe_r <= 1'b1;
            status_r <= ibss_pkg::ST_DONE;
            fill_r   <= count_r + ibss_pkg::CNT_W'(1);
            bout_r   <= '0;
            bvalid_r <= 1'b0;
            last_r   <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            state_r <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          idx_r   <= idx_dec;
          state_r <= S_INS_RD;
        end
        // remove: move elements down one slot from the index to the tail
        S_REM_RD: begin
          if (rem_end) begin
            count_r  <= count_r - ibss_pkg::CNT_W'(1);
            strobe_r <= 1'b1;
            status_r <= ibss_pkg::ST_DONE;
            fill_r   <= count_r - ibss_pkg::CNT_W'(1);
            bout_r   <= '0;
            bvalid_r <= 1'b0;
            last_r   <= 1'b1;
            state_r  <= S_IDLE;
          end else begin
            state_r <= S_REM_WR;
          end
        end
        S_REM_WR: begin
          idx_r   <= idx_inc;
          state_r <= S_REM_RD;
        end
        // dump: one read, one beat per element
        S_DMP_RD: begin
          state_r <= S_DMP_OUT;
        end
        S_DMP_OUT: begin
          strobe_r <= 1'b1;
          status_r <= ibss_pkg::ST_DONE;
          fill_r   <= count_r;
          bout_r   <= rdata_r;
          bvalid_r <= 1'b1;
          last_r   <= rem_end;
          idx_r    <= idx_inc;
          state_r  <= rem_end ? S_IDLE : S_DMP_RD;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_fill_count = fill_r;
  assign out_byte_out   = bout_r;
  assign out_byte_valid = bvalid_r;
  assign out_last       = last_r;

endmodule

@@ hdl/ibss_check.sv @@
// ibss_check: range, empty and full checks on an incoming command.
// Depends on ibss_pkg for codes and the chk_t result struct.
module ibss_check #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic [ibss_pkg::KIND_W-1:0] kind,
  input  logic [ibss_pkg::POS_W-1:0]  position,
  input  logic [ibss_pkg::CNT_W-1:0]  count,
  output ibss_pkg::chk_t              chk
);

  logic is_full;
  logic is_empty;

  assign is_full  = (count >= ibss_pkg::CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  // Decode kind against the current fill count
  always_comb begin
    chk.op        = ibss_pkg::OP_NONE;
    chk.status    = ibss_pkg::ST_DONE;
    chk.start_idx = '0;
    case (kind)
      ibss_pkg::KIND_APPEND: begin
        if (is_full) begin
          chk.status = ibss_pkg::ST_FULL;
        end else begin
          chk.op = ibss_pkg::OP_APPEND;
        end
      end
      ibss_pkg::KIND_INSERT: begin
        // range check wins over full check
        if (ibss_pkg::CNT_W'(position) > count) begin
          chk.status = ibss_pkg::ST_RANGE;
        end else if (is_full) begin
          chk.status = ibss_pkg::ST_FULL;
        end else begin
          chk.op        = ibss_pkg::OP_INSERT;
          chk.start_idx = count;
        end
      end
      ibss_pkg::KIND_REMOVE_AT: begin
        if (ibss_pkg::CNT_W'(position) >= count) begin
          chk.status = ibss_pkg::ST_RANGE;
        end else begin
          chk.op        = ibss_pkg::OP_REMOVE;
          chk.start_idx = ibss_pkg::CNT_W'(position);
        end
      end
      ibss_pkg::KIND_REMOVE_FIRST: begin
        if (is_empty) begin
          chk.status = ibss_pkg::ST_RANGE;
        end else begin
          chk.op = ibss_pkg::OP_REMOVE;
        end
      end
      ibss_pkg::KIND_REMOVE_LAST: begin
        if (is_empty) begin
          chk.status = ibss_pkg::ST_RANGE;
        end else begin
          chk.op = ibss_pkg::OP_DROP_LAST;
        end
      end
      ibss_pkg::KIND_DUMP: begin
        // empty dump gives one plain done beat
        if (!is_empty) begin
          chk.op = ibss_pkg::OP_DUMP;
        end
      end
      default: begin
        chk.status = ibss_pkg::ST_RANGE;
      end
    endcase
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for indexed_byte_sequence_store_top: sends list commands over the
// start/busy port and checks every result beat against a shadow copy of the list.
// Depends on ibss_pkg and the store RTL; needs no files or arguments.
module testbench;
  import ibss_pkg::*;

  localparam int DEPTH          = 32;
  localparam int HALF_PERIOD    = 6;
  localparam int DRAIN_CYCLES   = 4 * DEPTH + 16;
  localparam int TIMEOUT_CYCLES = 300000;

  // Kind codes the store does not define; both must be rejected
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  fill_count;
    logic [BYTE_W-1:0] byte_out;
    logic              byte_valid;
    logic              last;
  } beat_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] in_kind;
  logic [POS_W-1:0]  in_position;
  logic [BYTE_W-1:0] in_byte_in;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0]  out_fill_count;
  logic [BYTE_W-1:0] out_byte_out;
  logic              out_byte_valid;
  logic              out_last;

  // Shadow list and the beats it says the store owes us
  logic [BYTE_W-1:0] shadow_bytes [DEPTH];
  int                shadow_count = 0;
  beat_t             pending_beats [$];

  int idle_pct    = 0;
  int error_count = 0;
  int cmd_count   = 0;
  int beat_count  = 0;
  int reject_count = 0;
  int peak_fill   = 0;

  indexed_byte_sequence_store_top #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_position   (in_position),
    .in_byte_in    (in_byte_in),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_fill_count(out_fill_count),
    .out_byte_out  (out_byte_out),
    .out_byte_valid(out_byte_valid),
    .out_last      (out_last)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Apply one accepted command to the shadow list and queue the beats it owes
  function automatic void apply_list_cmd(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                         logic [BYTE_W-1:0] data);
    logic [STAT_W-1:0] st;
    int i;
    st = ST_DONE;
    if (kind == KIND_DUMP) begin
      if (shadow_count == 0) begin
        pending_beats.push_back(beat_t'{ST_DONE, CNT_W'(0), BYTE_W'(0), 1'b0, 1'b1});
      end else begin
        for (i = 0; i < shadow_count; i++) begin
          pending_beats.push_back(beat_t'{ST_DONE, CNT_W'(shadow_count), shadow_bytes[i],
                                           1'b1, (i == shadow_count - 1)});
        end
      end
    end else begin
      case (kind)
        KIND_APPEND: begin
          if (shadow_count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            shadow_bytes[shadow_count] = data;
            shadow_count++;
          end
        end
        KIND_INSERT: begin
          // range check wins over the full check
          if (int'(pos) > shadow_count) begin
            st = ST_RANGE;
          end else if (shadow_count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            for (i = shadow_count; i > int'(pos); i--) shadow_bytes[i] = shadow_bytes[i - 1];
            shadow_bytes[pos] = data;
            shadow_count++;
          end
        end
        KIND_REMOVE_AT: begin
          if (int'(pos) >= shadow_count) begin
            st = ST_RANGE;
          end else begin
            for (i = int'(pos); i + 1 < shadow_count; i++) shadow_bytes[i] = shadow_bytes[i + 1];
            shadow_count--;
          end
        end
        KIND_REMOVE_FIRST: begin
          if (shadow_count == 0) begin
            st = ST_RANGE;
          end else begin
            for (i = 0; i + 1 < shadow_count; i++) shadow_bytes[i] = shadow_bytes[i + 1];
            shadow_count--;
          end
        end
        KIND_REMOVE_LAST: begin
          if (shadow_count == 0) st = ST_RANGE;
          else shadow_count--;
        end
        default: st = ST_RANGE;
      endcase
      if (st != ST_DONE) reject_count++;
      pending_beats.push_back(beat_t'{st, CNT_W'(shadow_count), BYTE_W'(0), 1'b0, 1'b1});
    end
    if (shadow_count > peak_fill) peak_fill = shadow_count;
  endfunction

  // Drive one command, idling first at the current rate, and hold it until taken
  task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                          input logic [BYTE_W-1:0] data);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_byte_in  <= data;
    do @(posedge clk); while (busy);
    apply_list_cmd(kind, pos, data);
    cmd_count++;
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Every strobed beat is taken at the edge that ends its cycle
  always @(posedge clk) begin : result_check
    beat_t want;
    if (rst_n && out_strobe) begin
      beat_count++;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: status %0d fill %0d byte %0d",
               out_status, out_fill_count, out_byte_out);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        check_field("status", want.status, out_status);
        check_field("fill_count", want.fill_count, out_fill_count);
        check_field("byte_out", want.byte_out, out_byte_out);
        check_field("byte_valid", want.byte_valid, out_byte_valid);
        check_field("last", want.last, out_last);
      end
    end
  end

  // Empty-store rejections, inserts at front/middle/end, removes, spare kinds
  task automatic test_directed();
    send_cmd(KIND_DUMP, 6'd0, 8'h00);          // dump of an empty store
    send_cmd(KIND_REMOVE_FIRST, 6'd0, 8'h00);
    send_cmd(KIND_REMOVE_LAST, 6'd0, 8'h00);
    send_cmd(KIND_REMOVE_AT, 6'd0, 8'h00);
    send_cmd(KIND_INSERT, 6'd1, 8'h77);         // past the end of an empty store
    send_cmd(KIND_INSERT, 6'd0, 8'hA5);         // insert at count acts as append
    send_cmd(KIND_APPEND, 6'd63, 8'h00);
    send_cmd(KIND_APPEND, 6'd0, 8'hFF);
    send_cmd(KIND_INSERT, 6'd1, 8'h5A);         // middle
    send_cmd(KIND_INSERT, 6'd4, 8'h81);         // at count
    send_cmd(KIND_INSERT, 6'd63, 8'h12);        // far past the end
    send_cmd(KIND_DUMP, 6'd0, 8'h00);
    send_cmd(KIND_REMOVE_AT, 6'd63, 8'h00);
    send_cmd(KIND_REMOVE_AT, 6'd5, 8'h00);      // index equal to count
    send_cmd(KIND_REMOVE_AT, 6'd1, 8'h00);
    send_cmd(KIND_REMOVE_FIRST, 6'd0, 8'h00);
    send_cmd(KIND_REMOVE_LAST, 6'd0, 8'h00);
    send_cmd(KIND_SPARE_6, 6'd63, 8'hFF);
    send_cmd(KIND_SPARE_7, 6'd0, 8'h00);
    send_cmd(KIND_DUMP, 6'd0, 8'h00);
    send_cmd(KIND_REMOVE_AT, 6'd1, 8'h00);
    send_cmd(KIND_REMOVE_AT, 6'd0, 8'h00);
    send_cmd(KIND_DUMP, 6'd0, 8'h00);
  endtask

  // Fill to capacity, then every full-store case and the longest shifts
  task automatic test_capacity();
    while (shadow_count < DEPTH) begin
      send_cmd(KIND_APPEND, POS_W'($urandom_range(0, 63)), BYTE_W'($urandom_range(0, 255)));
    end
    send_cmd(KIND_APPEND, 6'd0, 8'h3C);
    send_cmd(KIND_INSERT, 6'd0, 8'hC3);
    send_cmd(KIND_INSERT, POS_W'(DEPTH), 8'h11);
    send_cmd(KIND_INSERT, POS_W'(DEPTH + 1), 8'h22);  // range check before full check
    send_cmd(KIND_DUMP, 6'd0, 8'h00);
    send_cmd(KIND_REMOVE_AT, POS_W'(DEPTH - 1), 8'h00);
    send_cmd(KIND_INSERT, 6'd0, 8'hE7);
    send_cmd(KIND_REMOVE_AT, 6'd0, 8'h00);
    send_cmd(KIND_DUMP, 6'd0, 8'h00);
  endtask

  // Random commands; grow_pct steers the list toward full or toward empty
  task automatic test_random(input int n_items, input int grow_pct);
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    int                pick;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      pos  = POS_W'($urandom_range(0, 63));
      if (pick < 8) begin
        kind = KIND_DUMP;
      end else if (pick < 11) begin
        kind = $urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7;
      end else if ($urandom_range(0, 99) < grow_pct) begin
        kind = $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
        if (kind == KIND_INSERT && $urandom_range(0, 99) < 85) begin
          pos = POS_W'($urandom_range(0, shadow_count));
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       kind = KIND_REMOVE_AT;
          1:       kind = KIND_REMOVE_FIRST;
          default: kind = KIND_REMOVE_LAST;
        endcase
        if (kind == KIND_REMOVE_AT && shadow_count > 0 && $urandom_range(0, 99) < 85) begin
          pos = POS_W'($urandom_range(0, shadow_count - 1));
        end
      end
      send_cmd(kind, pos, BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Main sequence
  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_kind     <= KIND_APPEND;
    in_position <= '0;
    in_byte_in  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 0;
    test_directed();
    test_capacity();
    test_random(32, 70);
    idle_pct = 55;
    test_random(32, 50);
    idle_pct = 6;
    test_random(32, 25);
    start <= 1'b0;

    // drain, then give stray beats a chance to show up
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands (%0d rejected), %0d result beats checked, peak fill %0d of %0d.",
             cmd_count, reject_count, beat_count, peak_fill, DEPTH);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("Timed out with %0d beats still expected", pending_beats.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
